>>> design/wpq_pkg.sv
// ----------------------------------------------------------------------------
// wpq_pkg: shared types and constants
// Defines the stored entry layout, result status codes and register indexes.
// ----------------------------------------------------------------------------
package wpq_pkg;

  localparam int KEY_W    = 19;
  localparam int ID_W     = 16;
  localparam int SEV_W    = 4;
  localparam int WAIT_W   = 12;
  localparam int URG_W    = 4;
  localparam int AGE_W    = 7;
  localparam int SEX_W    = 2;
  localparam int MOBILE_W = 34;
  localparam int WGT_W    = 7;
  localparam int STAT_W   = 3;
  localparam int CFG_IDX_W = 2;

  typedef logic [STAT_W-1:0] status_t;
  localparam status_t ST_ADDED   = 3'd0;
  localparam status_t ST_REMOVED = 3'd1;
  localparam status_t ST_FULL    = 3'd2;
  localparam status_t ST_EMPTY   = 3'd3;
  localparam status_t ST_INVALID = 3'd4;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t REG_SEV_WEIGHT  = 2'd0;
  localparam cfg_idx_t REG_WAIT_WEIGHT = 2'd1;
  localparam cfg_idx_t REG_URG_WEIGHT  = 2'd2;

  localparam logic OP_ADD = 1'b0;

  typedef struct packed {
    logic [KEY_W-1:0]    key;
    logic [ID_W-1:0]     id;
    logic [SEV_W-1:0]    severity;
    logic [AGE_W-1:0]    age;
    logic [SEX_W-1:0]    sex;
    logic [MOBILE_W-1:0] mobile;
  } entry_t;

  typedef struct packed {
    logic [WGT_W-1:0] sev;
    logic [WGT_W-1:0] wait_m;
    logic [WGT_W-1:0] urg;
  } weights_t;

endpackage

>>> design/wpq_mem.sv
// ----------------------------------------------------------------------------
// wpq_mem: entry storage
// Single-port-write, single-port-read memory with registered read data.
// ----------------------------------------------------------------------------
module wpq_mem #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic            clk,
  input  logic            wr_en,
  input  logic [AW-1:0]   wr_addr,
  input  wpq_pkg::entry_t wr_data,
  input  logic [AW-1:0]   rd_addr,
  output wpq_pkg::entry_t rd_data
);
  import wpq_pkg::*;

  entry_t mem [DEPTH];
  entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

>>> design/wpq_key.sv
// ----------------------------------------------------------------------------
// wpq_key: priority key unit
// Two-stage weighted sum: products registered, then their sum registered.
// ----------------------------------------------------------------------------
module wpq_key (
  input  logic                          clk,
  input  logic                          load,
  input  wpq_pkg::weights_t             weights,
  input  logic [wpq_pkg::SEV_W-1:0]     severity,
  input  logic [wpq_pkg::WAIT_W-1:0]    wait_minutes,
  input  logic [wpq_pkg::URG_W-1:0]     urgency,
  output logic [wpq_pkg::KEY_W-1:0]     key
);
  import wpq_pkg::*;

  logic [WGT_W+SEV_W-1:0]  p_sev_r;
  logic [WGT_W+WAIT_W-1:0] p_wait_r;
  logic [WGT_W+URG_W-1:0]  p_urg_r;
  logic [KEY_W-1:0]        key_r;

  always_ff @(posedge clk) begin
    if (load) begin
      p_sev_r  <= weights.sev * severity;
      p_wait_r <= weights.wait_m * wait_minutes;
      p_urg_r  <= weights.urg * urgency;
    end
    key_r <= KEY_W'(p_wait_r) + KEY_W'(p_sev_r) + KEY_W'(p_urg_r);
  end

  assign key = key_r;

endmodule

>>> design/weighted_priority_queue_top.sv
// ----------------------------------------------------------------------------
// weighted_priority_queue_top: bounded priority queue
// Sorted ring buffer in one memory; adds walk from the tail, removes pop head.
// ----------------------------------------------------------------------------
// Usage: an input transfer (in_valid high, in_stall low) carries one
// operation. An add forms the weighted key and inserts the entry behind all
// entries with a greater or equal key; a remove pops the highest entry.
// Every item gives exactly one result transfer on the out_ channel.
// Entries sit in a ring in one memory with registered read data. A remove
// reads the head at acceptance and takes its data in S_CMP. An add forms
// the key in S_KEY, then moves stored entries with a lower key one slot up
// from the tail, each moved entry passing S_RD (read) and then S_CMP
// (compare and write back); at most QUEUE_DEPTH-1 entries are moved.
// Rejected items (invalid, full, empty) go straight to S_FIN. One item is
// in work at a time: in_stall is high from acceptance until its result
// sits in the output register. The result register holds while out_stall
// is high; the next item can be accepted meanwhile and waits only when its
// own result is ready. Reset empties the queue, sets the next id to one and
// the weights to 50, 30 and 20 hundredths. Weights are written over the
// cfg_ channel.
// ----------------------------------------------------------------------------
module weighted_priority_queue_top #(
  parameter int QUEUE_DEPTH = 64
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_operation,
  input  logic [wpq_pkg::SEV_W-1:0]      in_severity,
  input  logic [wpq_pkg::WAIT_W-1:0]     in_wait_minutes,
  input  logic [wpq_pkg::URG_W-1:0]      in_urgency,
  input  logic [wpq_pkg::AGE_W-1:0]      in_age,
  input  logic [wpq_pkg::SEX_W-1:0]      in_sex,
  input  logic [wpq_pkg::MOBILE_W-1:0]   in_mobile_number,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [wpq_pkg::STAT_W-1:0]     out_status,
  output logic [wpq_pkg::ID_W-1:0]       out_entry_id,
  output logic [wpq_pkg::SEV_W-1:0]      out_severity,
  output logic [wpq_pkg::AGE_W-1:0]      out_age,
  output logic [wpq_pkg::SEX_W-1:0]      out_sex,
  output logic [wpq_pkg::MOBILE_W-1:0]   out_mobile,
  output logic [wpq_pkg::KEY_W-1:0]      out_priority_key,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [wpq_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [wpq_pkg::WGT_W-1:0]      cfg_data
);
  import wpq_pkg::*;

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [AW:0]   DEPTH_S   = (AW+1)'(QUEUE_DEPTH);
  localparam logic [AW-1:0] LAST_ADDR = AW'(QUEUE_DEPTH - 1);
  localparam logic [CW-1:0] DEPTH_C   = CW'(QUEUE_DEPTH);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_KEY   = 6'b000010,
    S_RD    = 6'b000100,
    S_CMP   = 6'b001000,
    S_WRNEW = 6'b010000,
    S_FIN   = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  weights_t weights_r;
  logic [AW-1:0] head_r, head_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [AW-1:0] hole_r, hole_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [ID_W-1:0] next_id_r, next_id_nxt;

  // Latched payload of the add in work.
  logic [SEV_W-1:0]    sev_r;
  logic [AGE_W-1:0]    age_r;
  logic [SEX_W-1:0]    sex_r;
  logic [MOBILE_W-1:0] mob_r;

  entry_t res_r, res_nxt;
  status_t res_stat_r, res_stat_nxt;

  logic          out_valid_r;
  status_t       out_stat_r;
  entry_t        out_ent_r;

  logic          in_xfer, out_free;
  logic          sev_ok, urg_ok;
  logic [KEY_W-1:0] key;
  logic [AW-1:0] hole_m1, rd_addr, wr_addr;
  logic [AW:0]   tail_sum;
  logic [AW-1:0] tail;
  logic          wr_en;
  entry_t        wr_data, rd_data, new_ent;

  assign in_stall  = (state_r != S_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || !out_stall;

  assign sev_ok = (in_severity >= SEV_W'(1)) && (in_severity <= SEV_W'(10));
  assign urg_ok = (in_urgency  >= URG_W'(1)) && (in_urgency  <= URG_W'(10));

  assign hole_m1  = (hole_r == '0) ? LAST_ADDR : hole_r - AW'(1);
  assign tail_sum = {1'b0, head_r} + (AW+1)'(count_r);
  assign tail     = (tail_sum >= DEPTH_S) ? AW'(tail_sum - DEPTH_S) : tail_sum[AW-1:0];
  assign rd_addr  = (state_r == S_IDLE) ? head_r : hole_m1;

  assign new_ent = '{key: key, id: next_id_r, severity: sev_r, age: age_r,
                     sex: sex_r, mobile: mob_r};

  wpq_key u_key (
    .clk          (clk),
    .load         (in_xfer),
    .weights      (weights_r),
    .severity     (in_severity),
    .wait_minutes (in_wait_minutes),
    .urgency      (in_urgency),
    .key          (key)
  );

  wpq_mem #(.DEPTH(QUEUE_DEPTH), .AW(AW)) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_comb begin
    state_nxt    = state_r;
    head_nxt     = head_r;
    count_nxt    = count_r;
    hole_nxt     = hole_r;
    cnt_nxt      = cnt_r;
    next_id_nxt  = next_id_r;
    res_nxt      = res_r;
    res_stat_nxt = res_stat_r;
    wr_en        = 1'b0;
    wr_addr      = hole_r;
    wr_data      = new_ent;
    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          res_nxt = '0;
          if (in_operation == OP_ADD) begin
            if (!sev_ok || !urg_ok) begin
              res_stat_nxt = ST_INVALID;
              state_nxt    = S_FIN;
            end else if (count_r == DEPTH_C) begin
              res_stat_nxt = ST_FULL;
              state_nxt    = S_FIN;
            end else begin
              res_stat_nxt = ST_ADDED;
              state_nxt    = S_KEY;
            end
          end else if (count_r == '0) begin
            res_stat_nxt = ST_EMPTY;
            state_nxt    = S_FIN;
          end else begin
            // Head is being read this cycle; its data arrives in the next.
            res_stat_nxt = ST_REMOVED;
            state_nxt    = S_CMP;
          end
        end
      end
      S_KEY: begin
        hole_nxt  = tail;
        cnt_nxt   = count_r;
        state_nxt = (count_r == '0) ? S_WRNEW : S_RD;
      end
      S_RD: begin
        state_nxt = S_CMP;
      end
      S_CMP: begin
        if (res_stat_r == ST_REMOVED) begin
          res_nxt   = rd_data;
          head_nxt  = (head_r == LAST_ADDR) ? '0 : head_r + AW'(1);
          count_nxt = count_r - CW'(1);
          state_nxt = S_FIN;
        end else if (rd_data.key >= key) begin
          wr_en       = 1'b1;
          res_nxt     = '0;
          res_nxt.id  = next_id_r;
          res_nxt.key = key;
          next_id_nxt = next_id_r + ID_W'(1);
          count_nxt   = count_r + CW'(1);
          state_nxt   = S_FIN;
        end else begin
          // Move the lower entry one slot toward the tail.
          wr_en     = 1'b1;
          wr_data   = rd_data;
          hole_nxt  = hole_m1;
          cnt_nxt   = cnt_r - CW'(1);
          state_nxt = (cnt_r == CW'(1)) ? S_WRNEW : S_RD;
        end
      end
      S_WRNEW: begin
        wr_en       = 1'b1;
        res_nxt     = '0;
        res_nxt.id  = next_id_r;
        res_nxt.key = key;
        next_id_nxt = next_id_r + ID_W'(1);
        count_nxt   = count_r + CW'(1);
        state_nxt   = S_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      count_r     <= '0;
      next_id_r   <= ID_W'(1);
      out_valid_r <= 1'b0;
      weights_r   <= '{sev: WGT_W'(50), wait_m: WGT_W'(30), urg: WGT_W'(20)};
    end else begin
      state_r   <= state_nxt;
      head_r    <= head_nxt;
      count_r   <= count_nxt;
      next_id_r <= next_id_nxt;
      if (state_r == S_FIN && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_SEV_WEIGHT:  weights_r.sev    <= cfg_data;
          REG_WAIT_WEIGHT: weights_r.wait_m <= cfg_data;
          REG_URG_WEIGHT:  weights_r.urg    <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    hole_r     <= hole_nxt;
    cnt_r      <= cnt_nxt;
    res_r      <= res_nxt;
    res_stat_r <= res_stat_nxt;
    if (in_xfer) begin
      sev_r <= in_severity;
      age_r <= in_age;
      sex_r <= in_sex;
      mob_r <= in_mobile_number;
    end
    if (state_r == S_FIN && out_free) begin
      out_stat_r <= res_stat_r;
      out_ent_r  <= res_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_stat_r;
  assign out_entry_id     = out_ent_r.id;
  assign out_severity     = out_ent_r.severity;
  assign out_age          = out_ent_r.age;
  assign out_sex          = out_ent_r.sex;
  assign out_mobile       = out_ent_r.mobile;
  assign out_priority_key = out_ent_r.key;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= DEPTH_C)
    else $error("occupancy exceeds queue depth");

  a_walk_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RD) |-> (cnt_r != '0))
    else $error("insertion walk past the head");

  a_add_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WRNEW) |=> (count_r == $past(count_r) + CW'(1)))
    else $error("insert did not grow occupancy");

endmodule
